FILE: rtl/zcdp_pkg.sv
// Shared types and constants for the central directory parser.
package zcdp_pkg;

  localparam int unsigned NameCapacityDefault = 64;
  localparam logic [31:0] SigCentral  = 32'h02014b50;
  localparam int unsigned HeaderBytes = 46;

  // Result kind codes
  typedef enum logic [1:0] {
    KIND_ENTRY = 2'd0,
    KIND_NAME  = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  // One result as it leaves the front part; tdata layout follows field order
  typedef struct packed {
    logic        last_result;
    logic [7:0]  name_char;
    logic [15:0] extra_length;
    logic [15:0] name_length;
    logic [31:0] local_offset;
    logic [31:0] unpacked_size;
    logic [31:0] packed_size;
    logic [31:0] crc_value;
    logic [15:0] method;
    logic [15:0] entry_index;
    kind_t       kind;
  } result_t;

  localparam int unsigned ResultBits = $bits(result_t);

endpackage

FILE: rtl/zcdp_front.sv
// Front part: byte parser that classifies each byte and produces up to two results.
module zcdp_front import zcdp_pkg::*; #(
  parameter int unsigned NAME_CAPACITY = NameCapacityDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_data,
  input  logic        cfg_valid,
  input  logic [15:0] cfg_data,
  // up to two results per byte handed to the queue
  output logic        res0_valid,
  output result_t     res0,
  output logic        res1_valid,
  output result_t     res1,
  input  logic        room2
);

  typedef enum logic [1:0] {PH_HEADER, PH_TRAIL, PH_STOP} phase_t;

  localparam int unsigned KeepMax = NAME_CAPACITY - 1;

  phase_t      phase;
  logic [17:0] byte_position;
  logic [31:0] field_shift;
  logic [15:0] saved_name_length, saved_extra_length, saved_comment_length;
  logic [31:0] crc_reg, packed_reg, unpacked_reg;
  logic [15:0] method_code;
  logic        sig_good;
  logic [15:0] entries_done;
  logic [15:0] entry_count;
  logic [17:0] trail_total;
  logic [16:0] keep_len;

  logic        fire;
  logic [31:0] shift_next;
  logic        last_trail;
  logic [15:0] entries_inc;

  assign in_ready    = room2;
  assign fire        = in_valid & room2;
  assign shift_next  = {data_byte, field_shift[31:8]};
  assign entries_inc = entries_done + 16'd1;
  assign last_trail  = (byte_position + 18'd1) >= trail_total;

  // result generation for the current byte
  always_comb begin
    res0 = '0;
    res1 = '0;
    res0_valid = 1'b0;
    res1_valid = 1'b0;
    if (fire) begin
      case (phase)
        PH_HEADER: begin
          if (byte_position == '0 && entries_done >= entry_count) begin
            res0_valid = 1'b1;
            res0.kind = KIND_DONE;
            res0.entry_index = entries_done;
          end else if (byte_position == 18'(HeaderBytes - 1)) begin
            res0_valid = 1'b1;
            res0.entry_index = entries_done;
            if (!sig_good) begin
              res0.kind = KIND_ERROR;
            end else begin
              res0.kind          = KIND_ENTRY;
              res0.method        = method_code;
              res0.crc_value     = crc_reg;
              res0.packed_size   = packed_reg;
              res0.unpacked_size = unpacked_reg;
              res0.local_offset  = shift_next;
              res0.name_length   = saved_name_length;
              res0.extra_length  = saved_extra_length;
              if (end_of_data || (trail_total == '0 && entries_inc >= entry_count)) begin
                res1_valid = 1'b1;
                res1.kind = KIND_DONE;
                res1.entry_index = entries_inc;
              end
            end
          end else if (end_of_data) begin
            res0_valid = 1'b1;
            res0.kind = KIND_DONE;
            res0.entry_index = entries_done;
          end
        end
        PH_TRAIL: begin
          if ({1'b0, byte_position} < {1'b0, keep_len}) begin
            res0_valid = 1'b1;
            res0.kind = KIND_NAME;
            res0.entry_index = entries_done - 16'd1;
            res0.name_char = data_byte;
            if (end_of_data || (last_trail && entries_done >= entry_count)) begin
              res1_valid = 1'b1;
              res1.kind = KIND_DONE;
              res1.entry_index = entries_done;
            end
          end else if (end_of_data || (last_trail && entries_done >= entry_count)) begin
            res0_valid = 1'b1;
            res0.kind = KIND_DONE;
            res0.entry_index = entries_done;
          end
        end
        default: ;
      endcase
    end
    // mark the final result of this byte
    if (res1_valid) res1.last_result = 1'b1;
    else            res0.last_result = res0_valid;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      byte_position <= '0;
      field_shift <= '0;
      saved_name_length <= '0;
      saved_extra_length <= '0;
      saved_comment_length <= '0;
      crc_reg <= '0;
      packed_reg <= '0;
      unpacked_reg <= '0;
      method_code <= '0;
      sig_good <= 1'b0;
      entries_done <= '0;
      entry_count <= 16'd1;
      trail_total <= '0;
      keep_len <= '0;
    end else begin
      if (cfg_valid) entry_count <= cfg_data;
      // precomputed trailing length and retained name length
      trail_total <= 18'(saved_name_length) + 18'(saved_extra_length)
                   + 18'(saved_comment_length);
      keep_len <= (17'(saved_name_length) > 17'(KeepMax)) ? 17'(KeepMax)
                                                         : 17'(saved_name_length);
      if (fire) begin
        case (phase)
          PH_HEADER: begin
            if (byte_position == '0 && entries_done >= entry_count) begin
              phase <= PH_STOP;
            end else begin
              field_shift <= shift_next;
              case (byte_position)
                18'd3:  sig_good <= (shift_next == SigCentral);
                18'd11: method_code <= shift_next[31:16];
                18'd19: crc_reg <= shift_next;
                18'd23: packed_reg <= shift_next;
                18'd27: unpacked_reg <= shift_next;
                18'd29: saved_name_length <= shift_next[31:16];
                18'd31: saved_extra_length <= shift_next[31:16];
                18'd33: saved_comment_length <= shift_next[31:16];
                default: ;
              endcase
              if (byte_position == 18'(HeaderBytes - 1)) begin
                if (!sig_good) begin
                  phase <= PH_STOP;
                end else begin
                  entries_done <= entries_inc;
                  byte_position <= '0;
                  if (trail_total == '0) begin
                    if (end_of_data || entries_inc >= entry_count) phase <= PH_STOP;
                  end else if (end_of_data) begin
                    phase <= PH_STOP;
                  end else begin
                    phase <= PH_TRAIL;
                  end
                end
              end else if (end_of_data) begin
                phase <= PH_STOP;
              end else begin
                byte_position <= byte_position + 18'd1;
              end
            end
          end
          PH_TRAIL: begin
            if (end_of_data || (last_trail && entries_done >= entry_count)) begin
              phase <= PH_STOP;
            end else if (last_trail) begin
              phase <= PH_HEADER;
              byte_position <= '0;
            end else begin
              byte_position <= byte_position + 18'd1;
            end
          end
          default: ;
        endcase
      end
    end
  end

`ifndef NO_ASSERTIONS
  // no byte is taken without room for two results
  a_room: assert property (@(posedge clk) disable iff (rst) fire |-> room2)
    else $error("byte accepted without queue room");
  // a second result only follows a first one
  a_pair: assert property (@(posedge clk) disable iff (rst) res1_valid |-> res0_valid)
    else $error("second result without first");
  // once stopped the parser stays stopped
  a_stop: assert property (@(posedge clk) disable iff (rst)
    phase == PH_STOP |=> phase == PH_STOP)
    else $error("left stopped phase");
`endif

endmodule

FILE: rtl/zcdp_queue.sv
// Back part: result queue taking up to two results a cycle, draining one a cycle while the output is ready.
module zcdp_queue import zcdp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr0,
  input  result_t   din0,
  input  logic      wr1,
  input  result_t   din1,
  output logic      room2,
  output logic      out_valid,
  input  logic      out_ready,
  output result_t   dout
);

  localparam int unsigned Depth = 4;

  result_t     mem [Depth];
  logic [1:0]  wp, rp;
  logic [2:0]  count;
  logic        pop;
  logic [2:0]  pushes;

  assign out_valid = count != '0;
  assign dout      = mem[rp];
  assign pop       = out_valid & out_ready;
  assign pushes    = {2'b0, wr0} + {2'b0, wr1};
  assign room2     = count <= 3'(Depth - 2);

  // storage
  always_ff @(posedge clk) begin
    if (wr0) mem[wp] <= din0;
    if (wr1) mem[wp + 2'd1] <= din1;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      wp <= wp + pushes[1:0];
      if (pop) rp <= rp + 2'd1;
      count <= count + pushes - {2'b0, pop};
    end
  end

`ifndef NO_ASSERTIONS
  a_over: assert property (@(posedge clk) disable iff (rst) count <= 3'(Depth))
    else $error("queue overflow");
  a_order: assert property (@(posedge clk) disable iff (rst) wr1 |-> wr0)
    else $error("second write without first");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");
`endif

endmodule

FILE: rtl/zip_central_directory_parser.sv
// Top level of the ZIP central directory record parser.
// Takes one archive byte per transaction from the first central directory header on and
// returns entry headers, retained name characters and a final done or error result. A byte
// is taken every cycle while the four-entry result queue has room for two results; a byte
// gives at most two results, so with the output always ready the rate is one byte a cycle.
// Only the byte that ends parsing can give two results, so the queue never holds back the
// input while the output keeps up. Results leave the queue in the order they were made.
// The user must write the entry count register only while the block is idle; the block does not enforce it.
module zip_central_directory_parser import zcdp_pkg::*; #(
  parameter int unsigned NAME_CAPACITY = NameCapacityDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_byte
  input  logic         s_axis_tlast,   // end_of_data
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data,       // entry_count
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // kind[1:0], entry_index, method, crc_value, packed_size, unpacked_size,
  // local_offset, name_length, extra_length, name_char (from bit 0 up)
  output logic [207:0] m_axis_tdata,
  output logic         m_axis_tlast    // last_result
);

  result_t r0, r1, rq;
  logic    v0, v1, room2;

  assign cfg_ready = 1'b1;

  zcdp_front #(.NAME_CAPACITY(NAME_CAPACITY)) u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .data_byte(s_axis_tdata), .end_of_data(s_axis_tlast),
    .cfg_valid, .cfg_data,
    .res0_valid(v0), .res0(r0), .res1_valid(v1), .res1(r1), .room2
  );

  zcdp_queue u_queue (
    .clk, .rst,
    .wr0(v0), .din0(r0), .wr1(v1), .din1(r1), .room2,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .dout(rq)
  );

  // pack fields, kind lowest, zero pad to whole bytes
  assign m_axis_tdata = {6'b000000, rq.name_char, rq.extra_length, rq.name_length,
                         rq.local_offset, rq.unpacked_size, rq.packed_size,
                         rq.crc_value, rq.method, rq.entry_index, rq.kind};
  assign m_axis_tlast = rq.last_result;

endmodule

FILE: tb/sv/zip_central_directory_parser_tb.sv
// Self-checking testbench for the ZIP central directory parser.
module zip_central_directory_parser_tb;
  import zcdp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NameCap   = 64;
  localparam int unsigned CycleCap  = 600000;
  localparam int unsigned DrainWait = 30;

  typedef enum logic [1:0] {PH_HEADER, PH_TRAIL, PH_STOP} parse_phase_t;

  // Result fields, kind in the lowest bits of the struct so it packs like tdata
  typedef struct packed {
    logic [7:0]  name_char;
    logic [15:0] extra_length;
    logic [15:0] name_length;
    logic [31:0] local_offset;
    logic [31:0] unpacked_size;
    logic [31:0] packed_size;
    logic [31:0] crc_value;
    logic [15:0] method;
    logic [15:0] entry_index;
    kind_t       kind;
  } dir_result_t;

  typedef struct {
    dir_result_t fields;
    logic        last;
  } dir_item_t;

  // One central directory entry as the stimulus describes it
  typedef struct {
    logic        good_sig;
    logic [15:0] method;
    logic [31:0] crc;
    logic [31:0] psize;
    logic [31:0] usize;
    logic [31:0] offset;
    logic [15:0] nlen;
    logic [15:0] xlen;
    logic [15:0] clen;
  } dir_entry_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [15:0]  cfg_data = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [207:0] m_axis_tdata;
  logic         m_axis_tlast;

  zip_central_directory_parser #(.NAME_CAPACITY(NameCap)) DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always #6 clk = ~clk;

  // Predictor state
  parse_phase_t ph = PH_HEADER;
  logic [17:0]  pos = '0;
  logic [31:0]  shift = '0;
  logic [15:0]  nl = '0, xl = '0, cl = '0, meth = '0;
  logic [31:0]  hf [4] = '{default: '0};
  logic [15:0]  entries_parsed = '0;
  logic [15:0]  entry_limit = 16'd1;
  logic         sig_ok = 1'b0;

  dir_item_t   pending_results [$];
  dir_entry_t  typed_entries [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned bytes_sent = 0;
  bit          tx_burst = 0;
  bit          rx_burst = 0;
  bit          rx_hold = 0;

  function automatic dir_result_t blank_result(kind_t k, logic [15:0] idx);
    dir_result_t r;
    r = '0;
    r.kind = k;
    r.entry_index = idx;
    return r;
  endfunction

  // Work out the results one accepted byte causes
  task automatic parse_byte(logic [7:0] b, logic eod);
    dir_result_t res [$];
    dir_result_t r;
    dir_entry_t  t;
    dir_item_t   it;
    logic [31:0] total, keep;
    bit          at_end;
    total = {16'd0, nl} + {16'd0, xl} + {16'd0, cl};
    if (ph == PH_HEADER) begin
      if (pos == 0 && entries_parsed >= entry_limit) begin
        res.push_back(blank_result(KIND_DONE, entries_parsed));
        ph = PH_STOP;
      end else begin
        shift = {b, shift[31:8]};
        case (pos)
          3:  sig_ok = (shift == SigCentral);
          11: meth = shift[31:16];
          19: hf[0] = shift;
          23: hf[1] = shift;
          27: hf[2] = shift;
          29: nl = shift[31:16];
          31: xl = shift[31:16];
          33: cl = shift[31:16];
          45: hf[3] = shift;
          default: ;
        endcase
        if (pos == HeaderBytes - 1) begin
          if (!sig_ok) begin
            res.push_back(blank_result(KIND_ERROR, entries_parsed));
            ph = PH_STOP;
          end else begin
            r = blank_result(KIND_ENTRY, entries_parsed);
            r.method = meth;
            r.crc_value = hf[0];
            r.packed_size = hf[1];
            r.unpacked_size = hf[2];
            r.local_offset = hf[3];
            r.name_length = nl;
            r.extra_length = xl;
            res.push_back(r);
            // directed rows carry their header values typed in
            if (typed_entries.size() != 0) begin
              t = typed_entries.pop_front();
              if (r.method != t.method || r.crc_value != t.crc ||
                  r.packed_size != t.psize || r.unpacked_size != t.usize ||
                  r.local_offset != t.offset || r.name_length != t.nlen ||
                  r.extra_length != t.xlen) begin
                errors++;
                if (errors <= 10)
                  $display("directed entry %0d: header values differ", r.entry_index);
              end
            end
            entries_parsed++;
            pos = '0;
            total = {16'd0, nl} + {16'd0, xl} + {16'd0, cl};
            if (total == 0) begin
              if (eod || entries_parsed >= entry_limit) begin
                res.push_back(blank_result(KIND_DONE, entries_parsed));
                ph = PH_STOP;
              end
            end else if (eod) begin
              res.push_back(blank_result(KIND_DONE, entries_parsed));
              ph = PH_STOP;
            end else begin
              ph = PH_TRAIL;
            end
          end
        end else if (eod) begin
          res.push_back(blank_result(KIND_DONE, entries_parsed));
          ph = PH_STOP;
        end else begin
          pos++;
        end
      end
    end else if (ph == PH_TRAIL) begin
      keep = (nl > NameCap - 1) ? NameCap - 1 : {16'd0, nl};
      if ({14'd0, pos} < keep) begin
        r = blank_result(KIND_NAME, entries_parsed - 16'd1);
        r.name_char = b;
        res.push_back(r);
      end
      at_end = ({14'd0, pos} + 1 >= total);
      if (eod || (at_end && entries_parsed >= entry_limit)) begin
        res.push_back(blank_result(KIND_DONE, entries_parsed));
        ph = PH_STOP;
      end else if (at_end) begin
        ph = PH_HEADER;
        pos = '0;
      end else begin
        pos++;
      end
    end
    foreach (res[i]) begin
      it.fields = res[i];
      it.last = (i == res.size() - 1);
      pending_results.push_back(it);
    end
  endtask

  // Input and config monitor: predict on each accepted transaction
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata, s_axis_tlast);
    if (!rst && cfg_valid && cfg_ready) entry_limit = cfg_data;
  end

  // Output checker against the oldest pending result
  always @(posedge clk) begin
    dir_item_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: data %h last %b",
                                   m_axis_tdata[201:0], m_axis_tlast);
      end else begin
        e = pending_results.pop_front();
        if (m_axis_tdata[201:0] !== e.fields || m_axis_tlast !== e.last) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %h last %b, got %h last %b",
                                     e.fields, e.last, m_axis_tdata[201:0], m_axis_tlast);
        end
      end
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleCap) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Output side: random stalls, burst stretches and one long hold-off
  initial begin
    int unsigned g;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
      g = rx_burst ? 0 : $urandom_range(0, 14);
      if (g > 0) begin
        m_axis_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      while (rx_hold) begin
        m_axis_tready <= 1'b0;
        @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  // Offer one byte; tvalid stays high across back-to-back transactions
  task automatic send_byte(logic [7:0] b, logic eod);
    int unsigned g;
    g = tx_burst ? 0 : $urandom_range(0, 14);
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eod;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // Serialise one entry; eod_at marks the byte carrying end of data, -1 for none
  task automatic send_entry(dir_entry_t e, int eod_at);
    logic [7:0] hdr [46];
    int         total;
    foreach (hdr[i]) hdr[i] = 8'($urandom);
    {hdr[3], hdr[2], hdr[1], hdr[0]} =
      e.good_sig ? SigCentral : SigCentral ^ (32'd1 << $urandom_range(0, 31));
    {hdr[11], hdr[10]} = e.method;
    {hdr[19], hdr[18], hdr[17], hdr[16]} = e.crc;
    {hdr[23], hdr[22], hdr[21], hdr[20]} = e.psize;
    {hdr[27], hdr[26], hdr[25], hdr[24]} = e.usize;
    {hdr[29], hdr[28]} = e.nlen;
    {hdr[31], hdr[30]} = e.xlen;
    {hdr[33], hdr[32]} = e.clen;
    {hdr[45], hdr[44], hdr[43], hdr[42]} = e.offset;
    total = 46 + e.nlen + e.xlen + e.clen;
    for (int i = 0; i < total; i++) begin
      send_byte(i < 46 ? hdr[i] : 8'($urandom), i == eod_at);
      if (i == eod_at) break;
    end
  endtask

  // Idle the input, drain results and let the block settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic write_entry_count(logic [15:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic dir_entry_t random_entry();
    dir_entry_t e;
    e.good_sig = 1'b1;
    e.method = 16'($urandom);
    e.crc = $urandom;
    e.psize = $urandom;
    e.usize = $urandom;
    e.offset = $urandom;
    e.nlen = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 6))
                                        : 16'($urandom_range(60, 70));
    e.xlen = 16'($urandom_range(0, 3));
    e.clen = 16'($urandom_range(0, 3));
    return e;
  endfunction

  // Directed entries: field extremes, empty trailer, name truncation edges
  dir_entry_t directed [6] = '{
    '{1'b1, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
      16'd0, 16'd0, 16'd0},
    '{1'b1, 16'h0000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
      16'd1, 16'd0, 16'd0},
    '{1'b1, 16'hAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h0F0F0F0F, 32'hF0F0F0F0,
      16'd63, 16'd0, 16'd1},
    '{1'b1, 16'h5555, 32'hAAAAAAAA, 32'h55555555, 32'hF0F0F0F0, 32'h0F0F0F0F,
      16'd64, 16'd2, 16'd0},
    '{1'b1, 16'h0008, 32'h12345678, 32'h00000001, 32'h80000000, 32'h00000000,
      16'd70, 16'd3, 16'd2},
    '{1'b1, 16'h0000, 32'h00000001, 32'hFFFFFFFF, 32'h00000000, 32'h7FFFFFFF,
      16'd0, 16'd0, 16'd5}
  };

  initial begin
    dir_entry_t e;
    int         n;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // highest count so that the run is not cut short
    write_entry_count(16'hFFFF);
    foreach (directed[i]) begin
      typed_entries.push_back(directed[i]);
      send_entry(directed[i], -1);
    end
    write_entry_count(16'(entries_parsed + 16'd40 + 16'($urandom_range(0, 1000))));

    // long output hold-off while the input keeps coming; names fill the queue
    fork
      begin
        rx_hold = 1;
        repeat (400) @(posedge clk);
        rx_hold = 0;
      end
    join_none
    tx_burst = 1;
    e = random_entry();
    e.nlen = 16'd8;
    send_entry(e, -1);
    e = random_entry();
    e.nlen = 16'd8;
    send_entry(e, -1);
    tx_burst = 0;

    // random entries, count register changed now and then
    n = 0;
    while (bytes_sent < 600) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      send_entry(random_entry(), -1);
      n++;
      if (n % 4 == 0)
        write_entry_count(16'($urandom_range(entries_parsed + 20, 65535)));
    end
    tx_burst = 0;

    // one way of ending the directory, then bytes that must be ignored
    e = random_entry();
    case ($urandom_range(0, 4))
      0: send_entry(e, $urandom_range(0, 44));
      1: begin
        e.good_sig = 1'b0;
        send_entry(e, -1);
      end
      2: begin
        e.nlen = 0; e.xlen = 0; e.clen = 0;
        send_entry(e, 45);
      end
      3: begin
        write_entry_count(16'd1);
        send_entry(e, -1);
      end
      default: begin
        write_entry_count(entries_parsed + 16'd1);
        send_entry(e, -1);
      end
    endcase
    repeat (8) send_byte(8'($urandom), 1'($urandom));

    wait_idle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
